FILE: sv/rqs_pkg.sv
// Shared types, sizes and the key normalizer for the record quicksort block.
// No dependencies; used by rqs_ctrl, rqs_dp and record_quicksort_by_key.
package rqs_pkg;

    localparam int MAX_RECORDS = 64;
    localparam int NAME_CHARS  = 8;
    localparam int ROLL_CHARS  = 8;
    localparam int KEY_W       = 64;
    localparam int AGE_W       = 7;
    localparam int IDX_W       = $clog2(MAX_RECORDS);
    localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
    localparam int REC_W       = 2 * KEY_W + AGE_W;
    localparam int DATA_W      = ((REC_W + 7) / 8) * 8;

    // Port A read address select
    localparam logic [1:0] ASEL_LO = 2'd0;
    localparam logic [1:0] ASEL_I  = 2'd1;
    localparam logic [1:0] ASEL_K  = 2'd2;

    // One record, name key in the low bits
    typedef struct packed {
        logic [AGE_W-1:0] age;
        logic [KEY_W-1:0] roll;
        logic [KEY_W-1:0] name;
    } t_rec;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic       load_wr;
        logic       cnt_clr;
        logic       sort_start;
        logic       pop;
        logic       range_ld;
        logic       piv_ld;
        logic       rd_a;
        logic [1:0] a_sel;
        logic       rd_b;
        logic       i_inc;
        logic       j_dec;
        logic       swap_a;
        logic       swap_b;
        logic       push_r;
        logic       push_l;
        logic       out_ld;
        logic       k_clr;
        logic       k_inc;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic cnt_zero;
        logic cnt_lt2;
        logic sp_zero;
        logic i_lt_hi;
        logic a_lt_piv;
        logic j_gt_lo;
        logic b_gt_piv;
        logic i_ge_j;
        logic last_k;
    } t_stat;

    // Keep the top chars bytes, clear everything from the first zero byte on
    function automatic logic [KEY_W-1:0] norm_key(input logic [KEY_W-1:0] key,
                                                  input int unsigned chars);
        logic [KEY_W-1:0] res;
        logic             done;
        logic [7:0]       b;
        res  = '0;
        done = 1'b0;
        for (int n = 0; n < KEY_W / 8; n++) begin
            b = key[KEY_W-1-8*n -: 8];
            if (n >= int'(chars) || b == 8'h00) begin
                done = 1'b1;
            end
            if (!done) begin
                res[KEY_W-1-8*n -: 8] = b;
            end
        end
        return res;
    endfunction

endpackage

FILE: sv/rqs_ctrl.sv
// Sequencer for load, Hoare partition quicksort and sorted readout.
// Depends on rqs_pkg; drives rqs_dp through t_cmd and reads t_stat.
module rqs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    input  logic          i_s_tlast,
    output logic          o_s_tready,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    input  rqs_pkg::t_stat i_stat,
    output rqs_pkg::t_cmd  o_cmd
);

    localparam logic [3:0] S_LOAD  = 4'd0;
    localparam logic [3:0] S_INIT  = 4'd1;
    localparam logic [3:0] S_POP   = 4'd2;
    localparam logic [3:0] S_RANGE = 4'd3;
    localparam logic [3:0] S_PIV   = 4'd4;
    localparam logic [3:0] S_RDI   = 4'd5;
    localparam logic [3:0] S_CMPI  = 4'd6;
    localparam logic [3:0] S_RDJ   = 4'd7;
    localparam logic [3:0] S_CMPJ  = 4'd8;
    localparam logic [3:0] S_SWA   = 4'd9;
    localparam logic [3:0] S_SWB   = 4'd10;
    localparam logic [3:0] S_PUSHR = 4'd11;
    localparam logic [3:0] S_PUSHL = 4'd12;
    localparam logic [3:0] S_ORD   = 4'd13;
    localparam logic [3:0] S_OLD   = 4'd14;
    localparam logic [3:0] S_OWAIT = 4'd15;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_s_tready = (r_state == S_LOAD);
    assign o_m_tvalid = (r_state == S_OWAIT);

    // Next state and command decode
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_LOAD: begin
                if (i_s_tvalid) begin
                    o_cmd.load_wr = 1'b1;
                    if (i_s_tlast) begin
                        n_state = S_INIT;
                    end
                end
            end
            S_INIT: begin
                o_cmd.sort_start = 1'b1;
                o_cmd.k_clr      = 1'b1;
                if (i_stat.cnt_zero) begin
                    o_cmd.cnt_clr = 1'b1;
                    n_state       = S_LOAD;
                end else if (i_stat.cnt_lt2) begin
                    n_state = S_ORD;
                end else begin
                    n_state = S_POP;
                end
            end
            S_POP: begin
                if (i_stat.sp_zero) begin
                    n_state = S_ORD;
                end else begin
                    o_cmd.pop = 1'b1;
                    n_state   = S_RANGE;
                end
            end
            S_RANGE: begin
                o_cmd.range_ld = 1'b1;
                o_cmd.rd_a     = 1'b1;
                o_cmd.a_sel    = rqs_pkg::ASEL_LO;
                n_state        = S_PIV;
            end
            S_PIV: begin
                o_cmd.piv_ld = 1'b1;
                n_state      = S_RDI;
            end
            S_RDI: begin
                o_cmd.rd_a  = 1'b1;
                o_cmd.a_sel = rqs_pkg::ASEL_I;
                n_state     = S_CMPI;
            end
            S_CMPI: begin
                if (i_stat.i_lt_hi && i_stat.a_lt_piv) begin
                    o_cmd.i_inc = 1'b1;
                    n_state     = S_RDI;
                end else begin
                    n_state = S_RDJ;
                end
            end
            S_RDJ: begin
                o_cmd.rd_b = 1'b1;
                n_state    = S_CMPJ;
            end
            S_CMPJ: begin
                if (i_stat.j_gt_lo && i_stat.b_gt_piv) begin
                    o_cmd.j_dec = 1'b1;
                    n_state     = S_RDJ;
                end else if (i_stat.i_ge_j) begin
                    n_state = S_PUSHR;
                end else begin
                    n_state = S_SWA;
                end
            end
            S_SWA: begin
                o_cmd.swap_a = 1'b1;
                n_state      = S_SWB;
            end
            S_SWB: begin
                o_cmd.swap_b = 1'b1;
                n_state      = S_RDI;
            end
            S_PUSHR: begin
                o_cmd.push_r = 1'b1;
                n_state      = S_PUSHL;
            end
            S_PUSHL: begin
                o_cmd.push_l = 1'b1;
                n_state      = S_POP;
            end
            S_ORD: begin
                o_cmd.rd_a  = 1'b1;
                o_cmd.a_sel = rqs_pkg::ASEL_K;
                n_state     = S_OLD;
            end
            S_OLD: begin
                o_cmd.out_ld = 1'b1;
                n_state      = S_OWAIT;
            end
            S_OWAIT: begin
                if (i_m_tready) begin
                    if (i_stat.last_k) begin
                        o_cmd.cnt_clr = 1'b1;
                        n_state       = S_LOAD;
                    end else begin
                        o_cmd.k_inc = 1'b1;
                        n_state     = S_ORD;
                    end
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: sv/rqs_dp.sv
// Datapath: record memory, range stack, partition indices and key compares.
// Depends on rqs_pkg; commanded by rqs_ctrl.
module rqs_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_wdata,
    input  logic [rqs_pkg::REC_W-1:0]  i_rec,
    input  rqs_pkg::t_cmd              i_cmd,
    output rqs_pkg::t_stat             o_stat,
    output logic [rqs_pkg::REC_W-1:0]  o_rec,
    output logic                       o_last
);

    localparam int IW = rqs_pkg::IDX_W;
    localparam int CW = rqs_pkg::CNT_W;
    localparam int KW = rqs_pkg::KEY_W;

    rqs_pkg::t_rec       r_mem [rqs_pkg::MAX_RECORDS];
    logic [2*IW-1:0]     r_stk [rqs_pkg::MAX_RECORDS];
    rqs_pkg::t_rec       r_rd_a;
    rqs_pkg::t_rec       r_rd_b;
    logic [2*IW-1:0]     r_stk_rd;
    rqs_pkg::t_rec       r_out;
    logic                r_out_last;
    logic                r_sort_field;
    logic                r_key_sel;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       r_sp;
    logic [IW-1:0]       r_lo;
    logic [IW-1:0]       r_hi;
    logic [IW-1:0]       r_i;
    logic [IW-1:0]       r_j;
    logic [IW-1:0]       r_k;
    logic [KW-1:0]       r_pivot;

    rqs_pkg::t_rec       in_rec;
    rqs_pkg::t_rec       norm_rec;
    logic [KW-1:0]       key_a;
    logic [KW-1:0]       key_b;
    logic [IW-1:0]       addr_a;
    logic                wr_en;
    logic [IW-1:0]       wr_addr;
    rqs_pkg::t_rec       wr_data;
    logic                stk_we;
    logic [2*IW-1:0]     stk_wdata;
    logic [IW-1:0]       stk_waddr;
    logic                sp_room;
    logic [IW:0]         j_plus1;

    assign in_rec        = i_rec;
    assign norm_rec.name = rqs_pkg::norm_key(in_rec.name, rqs_pkg::NAME_CHARS);
    assign norm_rec.roll = rqs_pkg::norm_key(in_rec.roll, rqs_pkg::ROLL_CHARS);
    assign norm_rec.age  = in_rec.age;

    assign key_a   = r_key_sel ? r_rd_a.roll : r_rd_a.name;
    assign key_b   = r_key_sel ? r_rd_b.roll : r_rd_b.name;
    assign sp_room = (r_sp < CW'(rqs_pkg::MAX_RECORDS));
    assign j_plus1 = {1'b0, r_j} + 1'b1;

    // Status back to the sequencer
    assign o_stat.cnt_zero = (r_count == '0);
    assign o_stat.cnt_lt2  = (r_count < CW'(2));
    assign o_stat.sp_zero  = (r_sp == '0);
    assign o_stat.i_lt_hi  = (r_i < r_hi);
    assign o_stat.a_lt_piv = (key_a < r_pivot);
    assign o_stat.j_gt_lo  = (r_j > r_lo);
    assign o_stat.b_gt_piv = (key_b > r_pivot);
    assign o_stat.i_ge_j   = (r_i >= r_j);
    assign o_stat.last_k   = ({1'b0, r_k} + 1'b1 == r_count);

    assign o_rec  = r_out;
    assign o_last = r_out_last;

    // Select port A read address; the pivot read takes lo straight from the popped range
    always_comb begin
        case (i_cmd.a_sel)
            rqs_pkg::ASEL_LO: addr_a = r_stk_rd[2*IW-1:IW];
            rqs_pkg::ASEL_I:  addr_a = r_i;
            default:          addr_a = r_k;
        endcase
    end

    // Select the single record write: load, or one half of a swap
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_i;
        wr_data = r_rd_b;
        if (i_cmd.load_wr) begin
            wr_en   = (r_count < CW'(rqs_pkg::MAX_RECORDS));
            wr_addr = r_count[IW-1:0];
            wr_data = norm_rec;
        end else if (i_cmd.swap_a) begin
            wr_en = 1'b1;
        end else if (i_cmd.swap_b) begin
            wr_en   = 1'b1;
            wr_addr = r_j;
            wr_data = r_rd_a;
        end
    end

    // Select the range stack write
    always_comb begin
        stk_we    = 1'b0;
        stk_waddr = r_sp[IW-1:0];
        stk_wdata = {r_lo, r_j};
        if (i_cmd.sort_start) begin
            stk_we    = !o_stat.cnt_lt2;
            stk_waddr = '0;
            stk_wdata = {IW'(0), IW'(r_count - 1'b1)};
        end else if (i_cmd.push_r) begin
            stk_we    = (j_plus1 < {1'b0, r_hi}) && sp_room;
            stk_wdata = {j_plus1[IW-1:0], r_hi};
        end else if (i_cmd.push_l) begin
            stk_we = (r_lo < r_j) && sp_room;
        end
    end

    // Record memory with registered reads
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_a) begin
            r_rd_a <= r_mem[addr_a];
        end
        if (i_cmd.rd_b) begin
            r_rd_b <= r_mem[r_j];
        end
    end

    // Range stack memory with registered read
    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stk[stk_waddr] <= stk_wdata;
        end
        if (i_cmd.pop) begin
            r_stk_rd <= r_stk[IW'(r_sp - 1'b1)];
        end
    end

    // Advance indices, pivot and output word
    always_ff @(posedge i_clk) begin
        if (i_cmd.range_ld) begin
            r_lo <= r_stk_rd[2*IW-1:IW];
            r_hi <= r_stk_rd[IW-1:0];
            r_i  <= r_stk_rd[2*IW-1:IW];
            r_j  <= r_stk_rd[IW-1:0];
        end else begin
            if (i_cmd.i_inc || i_cmd.swap_b) begin
                r_i <= r_i + 1'b1;
            end
            if (i_cmd.j_dec || i_cmd.swap_b) begin
                r_j <= r_j - 1'b1;
            end
        end
        if (i_cmd.piv_ld) begin
            r_pivot <= key_a;
        end
        if (i_cmd.sort_start) begin
            r_key_sel <= r_sort_field;
        end
        if (i_cmd.k_clr) begin
            r_k <= '0;
        end else if (i_cmd.k_inc) begin
            r_k <= r_k + 1'b1;
        end
        if (i_cmd.out_ld) begin
            r_out      <= r_rd_a;
            r_out_last <= o_stat.last_k;
        end
    end

    // Hold configuration, record count and stack pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sort_field <= 1'b0;
            r_count      <= '0;
            r_sp         <= '0;
        end else begin
            if (i_cfg_we) begin
                r_sort_field <= i_cfg_wdata;
            end
            if (i_cmd.cnt_clr) begin
                r_count <= '0;
            end else if (i_cmd.load_wr && r_count < CW'(rqs_pkg::MAX_RECORDS)) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.sort_start) begin
                r_sp <= o_stat.cnt_lt2 ? CW'(0) : CW'(1);
            end else if (i_cmd.pop) begin
                r_sp <= r_sp - 1'b1;
            end else if (stk_we) begin
                r_sp <= r_sp + 1'b1;
            end
        end
    end

endmodule

FILE: sv/record_quicksort_by_key.sv
// Top level of the record quicksort: stream ports around rqs_ctrl and rqs_dp.
// Depends on rqs_pkg, rqs_ctrl and rqs_dp.
//
//   channel   direction  handshake            payload
//   s         in         i_s_tvalid/o_s_tready  tdata: name_key, roll_key, age; tlast: last
//   m         out        o_m_tvalid/i_m_tready  tdata: name, roll, age; tlast: last
//   cfg       in         i_cfg_we             i_cfg_wdata: sort_field
//
// Records load one per cycle. After the last one the sort runs from one record
// memory with two read ports and one write port: each scan step is a registered
// read, then a compare, each swap two writes, and each range adds a pop, a range
// load, a pivot load and two pushes.
// Each readout word is read, loaded and held until taken. Reset is synchronous,
// active low, and clears the count, stack pointer and sort_field; no input word is
// taken while sorting or emitting, and a stalled output word holds.
module record_quicksort_by_key (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    // [63:0] name_key, [127:64] roll_key, [134:128] age, [135] zero
    input  logic [rqs_pkg::DATA_W-1:0]  i_s_tdata,
    input  logic                        i_s_tlast,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    // [63:0] out_name_key, [127:64] out_roll_key, [134:128] out_age, [135] zero
    output logic [rqs_pkg::DATA_W-1:0]  o_m_tdata,
    output logic                        o_m_tlast,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_wdata
);

    rqs_pkg::t_cmd                cmd;
    rqs_pkg::t_stat               stat;
    logic [rqs_pkg::REC_W-1:0]    out_rec;

    rqs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tlast  (i_s_tlast),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    rqs_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_rec       (i_s_tdata[rqs_pkg::REC_W-1:0]),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_rec       (out_rec),
        .o_last      (o_m_tlast)
    );

    // Pad the output word to whole bytes
    assign o_m_tdata = rqs_pkg::DATA_W'(out_rec);

endmodule

FILE: tb/rqs_checker.sv
// Checker for the record quicksort: watches the record and result channels,
// predicts the sorted run and compares every result word field by field.
// Depends on rqs_pkg for the data width and the record count limit.
`timescale 1ns / 1ps

module rqs_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_tvalid,
    input  logic                       i_s_tready,
    // [63:0] name_key, [127:64] roll_key, [134:128] age, [135] zero
    input  logic [rqs_pkg::DATA_W-1:0] i_s_tdata,
    input  logic                       i_s_tlast,
    input  logic                       i_m_tvalid,
    input  logic                       i_m_tready,
    // [63:0] out_name_key, [127:64] out_roll_key, [134:128] out_age, [135] zero
    input  logic [rqs_pkg::DATA_W-1:0] i_m_tdata,
    input  logic                       i_m_tlast,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_wdata,
    output int                         o_pending,
    output int                         o_errors
);

    localparam int DEPTH = rqs_pkg::MAX_RECORDS;

    typedef struct {
        logic [63:0] name;
        logic [63:0] roll;
        logic [6:0]  age;
        logic        last;
    } t_sorted_rec;

    // Shadow of the record store, the range stack and the key select
    logic [63:0] name_mem [DEPTH];
    logic [63:0] roll_mem [DEPTH];
    logic [6:0]  age_mem  [DEPTH];
    int          held;
    int          lo_stk   [DEPTH];
    int          hi_stk   [DEPTH];
    int          depth_ptr;
    logic        by_roll;

    t_sorted_rec sorted_q [$];
    int          errors;

    assign o_pending = sorted_q.size();
    assign o_errors  = errors;

    // Keep the top bytes up to the first zero byte, as a C string ends there
    function automatic logic [63:0] trim_key(logic [63:0] raw);
        logic [63:0] res;
        res = '0;
        for (int b = 7; b >= 0; b--) begin
            if (raw[8*b +: 8] == 8'h00) break;
            res[8*b +: 8] = raw[8*b +: 8];
        end
        return res;
    endfunction

    function automatic logic [63:0] key_of(int idx);
        return by_roll ? roll_mem[idx] : name_mem[idx];
    endfunction

    function automatic void swap_recs(int a, int b);
        logic [63:0] t;
        logic [6:0]  ta;
        t = name_mem[a]; name_mem[a] = name_mem[b]; name_mem[b] = t;
        t = roll_mem[a]; roll_mem[a] = roll_mem[b]; roll_mem[b] = t;
        ta = age_mem[a]; age_mem[a] = age_mem[b]; age_mem[b] = ta;
    endfunction

    // Hoare split with the first element as pivot
    function automatic int hoare_split(int lo, int hi);
        logic [63:0] pivot;
        int          i;
        int          j;
        bit          first;
        pivot = key_of(lo);
        i     = lo;
        j     = hi;
        first = 1'b1;
        while (1) begin
            if (!first) begin
                i++;
                j--;
            end
            first = 1'b0;
            while (i < hi && key_of(i) < pivot) i++;
            while (j > lo && key_of(j) > pivot) j--;
            if (i >= j) return j;
            swap_recs(i, j);
        end
    endfunction

    function automatic void push_range(int lo, int hi);
        if (lo < hi && depth_ptr < DEPTH) begin
            lo_stk[depth_ptr] = lo;
            hi_stk[depth_ptr] = hi;
            depth_ptr++;
        end
    endfunction

    // Sort the held set, queue it in order and empty the store
    function automatic void sort_and_queue();
        int          lo;
        int          hi;
        int          p;
        t_sorted_rec r;
        depth_ptr = 0;
        if (held >= 2) begin
            push_range(0, held - 1);
            while (depth_ptr > 0) begin
                depth_ptr--;
                lo = lo_stk[depth_ptr];
                hi = hi_stk[depth_ptr];
                p  = hoare_split(lo, hi);
                push_range(p + 1, hi);
                push_range(lo, p);
            end
        end
        for (int k = 0; k < held; k++) begin
            r.name = name_mem[k];
            r.roll = roll_mem[k];
            r.age  = age_mem[k];
            r.last = (k + 1 == held);
            sorted_q.push_back(r);
        end
        held = 0;
    endfunction

    always @(posedge i_clk) begin
        t_sorted_rec exp_r;
        logic [63:0] got_name;
        logic [63:0] got_roll;
        logic [6:0]  got_age;
        if (!i_rst_n) begin
            held    = 0;
            by_roll = 1'b0;
            sorted_q.delete();
            errors  = 0;
        end else begin
            if (i_cfg_we) by_roll = i_cfg_wdata;
            // Store an accepted record word, drop it once the store is full
            if (i_s_tvalid && i_s_tready) begin
                if (held < DEPTH) begin
                    name_mem[held] = trim_key(i_s_tdata[63:0]);
                    roll_mem[held] = trim_key(i_s_tdata[127:64]);
                    age_mem[held]  = i_s_tdata[134:128];
                    held++;
                end
                if (i_s_tlast) sort_and_queue();
            end
            // Compare an accepted result word with the oldest expectation
            if (i_m_tvalid && i_m_tready) begin
                got_name = i_m_tdata[63:0];
                got_roll = i_m_tdata[127:64];
                got_age  = i_m_tdata[134:128];
                if (sorted_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result: name %h roll %h age %0d last %b",
                                 got_name, got_roll, got_age, i_m_tlast);
                end else begin
                    exp_r = sorted_q.pop_front();
                    if (got_name !== exp_r.name || got_roll !== exp_r.roll ||
                        got_age !== exp_r.age || i_m_tlast !== exp_r.last) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: exp %h %h %0d %b, got %h %h %0d %b",
                                     exp_r.name, exp_r.roll, exp_r.age, exp_r.last,
                                     got_name, got_roll, got_age, i_m_tlast);
                    end
                end
            end
        end
    end

endmodule

FILE: tb/tb_top.sv
// Stimulus and verdict for the record quicksort: sends record sets, flips the
// key select between sets and stalls both channels. Depends on rqs_pkg,
// record_quicksort_by_key and rqs_checker.
`timescale 1ns / 1ps

module tb_top;

    localparam int     DATA_W = rqs_pkg::DATA_W;
    localparam longint LIMIT  = 2000000;

    logic              i_clk;
    logic              i_rst_n;
    logic              s_valid;
    logic              s_ready;
    logic [DATA_W-1:0] s_data;
    logic              s_last;
    logic              m_valid;
    logic              m_ready;
    logic [DATA_W-1:0] m_data;
    logic              m_last;
    logic              cfg_we;
    logic              cfg_wdata;
    int                pending;
    int                errors;
    longint            cycles;
    int                sent;
    int                results_seen;

    record_quicksort_by_key u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_valid),
        .o_s_tready (s_ready),
        .i_s_tdata  (s_data),
        .i_s_tlast  (s_last),
        .o_m_tvalid (m_valid),
        .i_m_tready (m_ready),
        .o_m_tdata  (m_data),
        .o_m_tlast  (m_last),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata)
    );

    rqs_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_valid),
        .i_s_tready (s_ready),
        .i_s_tdata  (s_data),
        .i_s_tlast  (s_last),
        .i_m_tvalid (m_valid),
        .i_m_tready (m_ready),
        .i_m_tdata  (m_data),
        .i_m_tlast  (m_last),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata),
        .o_pending  (pending),
        .o_errors   (errors)
    );

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // Key with a mix of forms: full random, short strings that tie, junk past a zero
    function automatic logic [63:0] rand_key();
        logic [63:0] k;
        int          len;
        k = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: ;
            1, 2: begin
                len = $urandom_range(0, 3);
                k   = '0;
                for (int b = 0; b < len; b++)
                    k[63-8*b -: 8] = 8'h41 + 8'($urandom_range(0, 2));
            end
            default: k[8*$urandom_range(0, 7) +: 8] = 8'h00;
        endcase
        return k;
    endfunction

    // Offer one record word after a random gap, hold it until taken
    task automatic send_rec(logic [63:0] name, logic [63:0] roll, logic [6:0] age,
                            logic last);
        int gap;
        gap = $urandom_range(0, 7);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= {1'b0, age, roll, name};
        s_last  <= last;
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        sent++;
    endtask

    // Drain, let the block settle, then change the key select
    task automatic set_field(logic sel);
        s_valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (20) @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= sel;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic send_random_set(int n);
        for (int r = 0; r < n; r++)
            send_rec(rand_key(), rand_key(), 7'($urandom_range(0, 127)), r == n - 1);
    endtask

    // Receiver: random stalls, one long hold-off while the sender keeps offering
    initial begin
        int stall;
        m_ready = 1'b0;
        results_seen = 0;
        wait (i_rst_n);
        forever begin
            if (results_seen == 40) begin
                m_ready <= 1'b0;
                repeat (400) @(posedge i_clk);
            end else if (results_seen % 60 < 20) begin
                stall = 0;
            end else begin
                stall = $urandom_range(0, 7);
                if (stall > 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            m_ready <= 1'b1;
            @(posedge i_clk);
            while (!m_valid) @(posedge i_clk);
            results_seen++;
        end
    end

    initial begin
        int big_sets;
        int n;
        i_rst_n   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        s_last    = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = 1'b0;
        cycles    = 0;
        sent      = 0;
        big_sets  = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Single record with every bit set
        send_rec('1, '1, 7'd127, 1'b1);
        // Two records at the extremes, the larger first
        send_rec('1, '0, 7'd127, 1'b0);
        send_rec('0, '1, 7'd0, 1'b1);
        // Ties, embedded zero bytes and a key equal to its trimmed form
        send_rec(64'h4142_0043_4445_4647, 64'h3100_0000_0000_0000, 7'd1, 1'b0);
        send_rec(64'h4142_0000_0000_0000, 64'h3132_3334_3536_3738, 7'd2, 1'b0);
        send_rec(64'h4142_0000_0000_0000, 64'h3100_FFFF_FFFF_FFFF, 7'd3, 1'b0);
        send_rec(64'h00FF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001, 7'd4, 1'b0);
        send_rec(64'h4141_4141_4141_4141, 64'h3132_3334_3536_3737, 7'd5, 1'b0);
        send_rec(64'h4142_0000_0000_0001, 64'h3200_0000_0000_0000, 7'd6, 1'b1);
        // Same shapes sorted by roll key
        set_field(1'b1);
        send_rec(64'h5A00_0000_0000_0000, 64'h3300_0000_0000_0000, 7'd10, 1'b0);
        send_rec(64'h5900_0000_0000_0000, 64'h3300_0000_0000_0000, 7'd11, 1'b0);
        send_rec(64'h5800_0000_0000_0000, 64'h3100_5500_0000_0000, 7'd12, 1'b0);
        send_rec(64'h5700_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 7'd13, 1'b0);
        send_rec(64'h5600_0000_0000_0000, 64'h0000_0000_0000_0000, 7'd14, 1'b1);
        set_field(1'b0);

        // Random sets, mostly short, two that fill the store or overfill it
        while (sent < 270) begin
            if (big_sets < 2 && sent > 60 * (big_sets + 1)) begin
                n = 64 + $urandom_range(0, 3);
                big_sets++;
            end else begin
                n = $urandom_range(1, 10);
            end
            send_random_set(n);
            if ($urandom_range(0, 2) == 0) set_field(1'($urandom_range(0, 1)));
        end
        s_valid <= 1'b0;

        @(posedge i_clk);
        wait (pending == 0);
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
